/* hdl/l2rgb_pkg.sv */
package l2rgb_pkg;

   // pipeline depth, one register stage each
   localparam int NUM_STAGES = 14;

   // stream payload widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WHITE_X    = 3'd0,
      REG_WHITE_Y    = 3'd1,
      REG_WHITE_Z    = 3'd2,
      REG_CORR_RED   = 3'd3,
      REG_CORR_GREEN = 3'd4,
      REG_CORR_BLUE  = 3'd5,
      REG_A_LIMITS   = 3'd6,
      REG_B_LIMITS   = 3'd7
   } csr_index_type;

   // reset values
   localparam logic [17:0] WHITE_X_RST = 18'd62292;
   localparam logic [17:0] WHITE_Y_RST = 18'd65536;
   localparam logic [17:0] WHITE_Z_RST = 18'd71369;
   localparam logic [19:0] CORR_RST    = 20'd65536;
   localparam logic [31:0] LIMITS_RST  = 32'h7FFF8000;

   // lightness clamp, 100.0 in q8.8
   localparam logic [15:0] L_MAX = 16'd25600;

   // reciprocal constants for the constant divisions
   localparam logic [4:0]  P_DIV   = 5'd29;
   localparam logic [21:0] P_RECIP = 22'd2314098;   // floor(2^26 / 29)
   localparam logic [6:0]  A_DIV   = 7'd125;
   localparam logic [23:0] A_RECIP = 24'd8589934;   // floor(2^30 / 125)
   localparam logic [5:0]  B_DIV   = 6'd50;
   localparam logic [24:0] B_RECIP = 25'd21474836;  // floor(2^30 / 50)
   localparam logic signed [23:0] A_OFFSET = 24'sd2125000;  // 125 * 17000
   localparam logic signed [17:0] A_QOFF   = 18'sd17000;
   localparam logic signed [23:0] B_OFFSET = 24'sd2100000;  // 50 * 42000
   localparam logic signed [17:0] B_QOFF   = 18'sd42000;

   // companding constants, q.16
   localparam logic signed [18:0] KNEE     = 19'sd13559;  // 6/29
   localparam logic signed [31:0] LIN_OFS  = 32'sd9039;   // 4/29
   localparam logic signed [31:0] LIN_SLOPE = 32'sd8416;  // 108/841

   // internal saturation limit
   localparam logic signed [18:0] INT_MAX = 19'sd262143;

   // xyz to linear srgb matrix, q.16
   localparam logic signed [18:0] XYZ_TO_RGB [3][3] = '{
      '{ 19'sd212376, -19'sd100742, -19'sd32676 },
      '{ -19'sd63498,  19'sd122932,  19'sd2720  },
      '{ 19'sd3650,   -19'sd13369,   19'sd69272 }
   };

endpackage

/* hdl/lab_to_rgb_converter.sv */
// cie lab to 8-bit rgb pixel converter. each req beat carries one pixel (l* unsigned q8.8,
// a* and b* signed q8.8); each rsp beat carries the matching red, green and blue bytes, in
// order. the datapath is a 14-stage pipeline that takes one pixel per clock unless
// back-pressure from a stalled output fills every stage; a stalled output does not drop
// throughput until every stage holds a pixel, since empty stages keep filling. white point,
// correction factors and a*/b* clamp limits come from the csr write port and must only be
// changed while no pixel is in flight.
module lab_to_rgb_converter
   import l2rgb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input pixel stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // l_star[15:0], a_star[31:16], b_star[47:32]
   // output rgb stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // red[7:0], green[15:8], blue[23:16]
   // configuration writes
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // saturate to the signed q2.16 internal range
   function automatic logic signed [18:0] sat19(input logic signed [47:0] v);
      logic signed [18:0] r;
      if (v > 48'(INT_MAX))
         r = INT_MAX;
      else if (v < -48'(INT_MAX) - 48'sd1)
         r = -INT_MAX - 19'sd1;
      else
         r = v[18:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------
   logic [17:0] white_ff [3];
   logic [19:0] corr_ff  [3];
   logic [31:0] a_lim_ff;
   logic [31:0] b_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff[0] <= WHITE_X_RST;
         white_ff[1] <= WHITE_Y_RST;
         white_ff[2] <= WHITE_Z_RST;
         corr_ff[0]  <= CORR_RST;
         corr_ff[1]  <= CORR_RST;
         corr_ff[2]  <= CORR_RST;
         a_lim_ff    <= LIMITS_RST;
         b_lim_ff    <= LIMITS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_WHITE_X:    white_ff[0] <= csr_wdata[17:0];
            REG_WHITE_Y:    white_ff[1] <= csr_wdata[17:0];
            REG_WHITE_Z:    white_ff[2] <= csr_wdata[17:0];
            REG_CORR_RED:   corr_ff[0]  <= csr_wdata[19:0];
            REG_CORR_GREEN: corr_ff[1]  <= csr_wdata[19:0];
            REG_CORR_BLUE:  corr_ff[2]  <= csr_wdata[19:0];
            REG_A_LIMITS:   a_lim_ff    <= csr_wdata;
            REG_B_LIMITS:   b_lim_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // pipeline control: a stage loads when it is empty or the next one moves,
   // so bubbles are squeezed out even while the output is stalled
   // ---------------------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in = {vld_ff[NUM_STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------------------
   // stage 0: clamp inputs and form the dividends
   //   p = (64*(l+4096) + 14) / 29
   //   a term = (64*a + 62) / 125, b term = (64*b + 25) / 50, both offset positive
   // ---------------------------------------------------------------------------
   logic [15:0]        l_raw;
   logic signed [15:0] a_raw, b_raw, a_lo, a_hi, b_lo, b_hi;
   logic [15:0]        l_cl;
   logic signed [15:0] a_cl, b_cl;
   logic signed [23:0] na_s, nb_s;
   logic [20:0]        np_in, np_ff;
   logic [22:0]        na_in, na_ff, nb_in, nb_ff;

   always_comb begin
      l_raw = req_tdata[15:0];
      a_raw = signed'(req_tdata[31:16]);
      b_raw = signed'(req_tdata[47:32]);
      a_lo  = signed'(a_lim_ff[15:0]);
      a_hi  = signed'(a_lim_ff[31:16]);
      b_lo  = signed'(b_lim_ff[15:0]);
      b_hi  = signed'(b_lim_ff[31:16]);

      l_cl = (l_raw > L_MAX) ? L_MAX : l_raw;

      // max first, then min, so an inverted window yields the minimum
      a_cl = (a_raw > a_hi) ? a_hi : a_raw;
      if (a_cl < a_lo) a_cl = a_lo;
      b_cl = (b_raw > b_hi) ? b_hi : b_raw;
      if (b_cl < b_lo) b_cl = b_lo;

      np_in = {15'(l_cl) + 15'd4096, 6'b0} + 21'd14;
      na_s  = (24'(a_cl) <<< 6) + 24'sd62 + A_OFFSET;
      nb_s  = (24'(b_cl) <<< 6) + 24'sd25 + B_OFFSET;
      na_in = na_s[22:0];
      nb_in = nb_s[22:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         np_ff <= np_in;
         na_ff <= na_in;
         nb_ff <= nb_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 1: reciprocal multiply, quotient estimate is exact or one low
   // ---------------------------------------------------------------------------
   logic [42:0] prod_p;
   logic [46:0] prod_a;
   logic [47:0] prod_b;
   logic [16:0] qp0_in, qp0_ff, qa0_in, qa0_ff;
   logic [17:0] qb0_in, qb0_ff;
   logic [20:0] np1_ff;
   logic [22:0] na1_ff, nb1_ff;

   always_comb begin
      prod_p = 43'(np_ff) * 43'(P_RECIP);
      prod_a = 47'(na_ff) * 47'(A_RECIP);
      prod_b = 48'(nb_ff) * 48'(B_RECIP);
      qp0_in = prod_p[42:26];
      qa0_in = prod_a[46:30];
      qb0_in = prod_b[47:30];
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         qp0_ff <= qp0_in;
         qa0_ff <= qa0_in;
         qb0_ff <= qb0_in;
         np1_ff <= np_ff;
         na1_ff <= na_ff;
         nb1_ff <= nb_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 2: remainder check fixes the quotient, offsets come back off
   // ---------------------------------------------------------------------------
   logic [23:0]        rp, ra, rb;
   logic [16:0]        qa_pos;
   logic [17:0]        qb_pos;
   logic [16:0]        p_in, p_ff;
   logic signed [17:0] qa_in, qa_ff, qb_in, qb_ff;

   always_comb begin
      rp = 24'(np1_ff) - 24'(qp0_ff) * 24'(P_DIV);
      ra = 24'(na1_ff) - 24'(qa0_ff) * 24'(A_DIV);
      rb = 24'(nb1_ff) - 24'(qb0_ff) * 24'(B_DIV);
      p_in   = qp0_ff + 17'(rp >= 24'(P_DIV));
      qa_pos = qa0_ff + 17'(ra >= 24'(A_DIV));
      qb_pos = qb0_ff + 18'(rb >= 24'(B_DIV));
      qa_in  = signed'({1'b0, qa_pos}) - A_QOFF;
      qb_in  = signed'(qb_pos) - B_QOFF;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         p_ff  <= p_in;
         qa_ff <= qa_in;
         qb_ff <= qb_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 3: l, m, n (sums stay well inside the internal range)
   // ---------------------------------------------------------------------------
   logic signed [18:0] p_s;
   logic signed [18:0] x_in [3];
   logic signed [18:0] x_ff [3];

   always_comb begin
      p_s     = signed'({2'b0, p_ff});
      x_in[0] = p_s + 19'(qa_ff);
      x_in[1] = p_s;
      x_in[2] = p_s - 19'(qb_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         x_ff <= x_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stages 4-6: inverse companding, cube above the knee, line below it
   // ---------------------------------------------------------------------------
   logic [33:0]        sq_in   [3];
   logic [33:0]        sq_ff   [3];
   logic [16:0]        xu_ff   [3];
   logic signed [31:0] dx      [3];
   logic signed [31:0] lin_in  [3];
   logic signed [31:0] lin_ff  [3];
   logic [2:0]         cub_in, cub_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cub_in[i] = (x_ff[i] >= KNEE);
         sq_in[i]  = 34'(x_ff[i][16:0]) * 34'(x_ff[i][16:0]);
         dx[i]     = 32'(x_ff[i]) - LIN_OFS;
         lin_in[i] = dx[i] * LIN_SLOPE;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq_in[i];
            xu_ff[i] <= x_ff[i][16:0];
         end
         lin_ff <= lin_in;
         cub_ff <= cub_in;
      end
   end

   logic [50:0]        cube_in  [3];
   logic [50:0]        cube_ff  [3];
   logic signed [31:0] linr     [3];
   logic signed [18:0] linr_ff  [3];
   logic [2:0]         cub5_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cube_in[i] = 51'(sq_ff[i]) * 51'(xu_ff[i]);
         linr[i]    = (lin_ff[i] + 32'sd32768) >>> 16;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         cube_ff <= cube_in;
         for (int i = 0; i < 3; i++) begin
            linr_ff[i] <= linr[i][18:0];
         end
         cub5_ff <= cub_ff;
      end
   end

   logic [51:0]        cube_r [3];
   logic signed [18:0] g_in   [3];
   logic signed [18:0] g_ff   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cube_r[i] = (52'(cube_ff[i]) + 52'h0_0000_8000_0000) >> 32;
         if (!cub5_ff[i])
            g_in[i] = linr_ff[i];
         else if (cube_r[i] > 52'(INT_MAX))
            g_in[i] = INT_MAX;
         else
            g_in[i] = signed'(cube_r[i][18:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         g_ff <= g_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stages 7-8: white point scaling
   // ---------------------------------------------------------------------------
   logic signed [37:0] wp_in [3];
   logic signed [37:0] wp_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wp_in[i] = 38'(signed'({1'b0, white_ff[i]})) * 38'(g_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         wp_ff <= wp_in;
      end
   end

   logic signed [18:0] xyz_in [3];
   logic signed [18:0] xyz_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xyz_in[i] = sat19((48'(wp_ff[i]) + 48'sd32768) >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         xyz_ff <= xyz_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stages 9-10: matrix, nine constant products then row sums
   // ---------------------------------------------------------------------------
   logic signed [37:0] mp_in [3][3];
   logic signed [37:0] mp_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mp_in[i][j] = 38'(XYZ_TO_RGB[i][j]) * 38'(xyz_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         mp_ff <= mp_in;
      end
   end

   logic signed [47:0] acc    [3];
   logic signed [18:0] rgb_in [3];
   logic signed [18:0] rgb_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i]    = 48'(mp_ff[i][0]) + 48'(mp_ff[i][1]) + 48'(mp_ff[i][2]) + 48'sd32768;
         rgb_in[i] = sat19(acc[i] >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[10]) begin
         rgb_ff <= rgb_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stages 11-13: correction factor, clip to 0..1, scale to a byte
   // ---------------------------------------------------------------------------
   logic signed [39:0] cp_in [3];
   logic signed [39:0] cp_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cp_in[i] = 40'(rgb_ff[i]) * 40'(signed'({1'b0, corr_ff[i]}));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[11]) begin
         cp_ff <= cp_in;
      end
   end

   logic signed [39:0] vr   [3];
   logic [16:0]        v_in [3];
   logic [16:0]        v_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vr[i] = (cp_ff[i] + 40'sd32768) >>> 16;
         if (vr[i] < 40'sd0)
            v_in[i] = '0;
         else if (vr[i] > 40'sd65536)
            v_in[i] = 17'd65536;
         else
            v_in[i] = vr[i][16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[12]) begin
         v_ff <= v_in;
      end
   end

   logic [24:0] sc   [3];
   logic [7:0]  byte_in [3];
   logic [7:0]  byte_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sc[i]      = 25'(v_ff[i]) * 25'd255 + 25'd32768;
         byte_in[i] = sc[i][23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[13]) begin
         byte_ff <= byte_in;
      end
   end

   assign rsp_tdata = {byte_ff[2], byte_ff[1], byte_ff[0]};

endmodule

/* hdl/l2rgb_checker.sv */
module l2rgb_checker
   import l2rgb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // a held result does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp data changed while stalled");

   // an output that is empty or moving lets the whole pipe move
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("req stalled with a free output stage");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind lab_to_rgb_converter l2rgb_checker u_l2rgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
